>>> rtl/lidar_echo_feature_pixel_defines.svh
// assertion macros for the lidar echo feature pixel block
`ifndef LIDAR_ECHO_FEATURE_PIXEL_DEFINES_SVH
`define LIDAR_ECHO_FEATURE_PIXEL_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication on clk, quiet during reset
`define LEFP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lefp check failed");
// next-cycle implication on clk, quiet during reset
`define LEFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lefp check failed");
`else
`define LEFP_ASSERT_NOW(lbl, ante, cons)
`define LEFP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/lefp_pkg.sv
// types, constants and the iteration step of the lidar echo feature pixel block
package lefp_pkg;

  localparam int unsigned NumIter = 40;
  localparam int unsigned NumEcho = 3;

  localparam logic [15:0] Lim16  = 16'd65533;
  localparam logic [7:0]  Lim8   = 8'd253;
  localparam logic [15:0] LimDst = 16'd65534;
  localparam logic [7:0]  PeakHi = 8'd254;
  localparam logic [4:0]  Tol    = 5'd25;

  // channel codes
  localparam logic [4:0] CH_AMBIENT    = 5'd0;
  localparam logic [4:0] CH_DIST       = 5'd1;
  localparam logic [4:0] CH_AREA       = 5'd2;
  localparam logic [4:0] CH_PEAK       = 5'd3;
  localparam logic [4:0] CH_WIDTH      = 5'd4;
  localparam logic [4:0] CH_AREA_W     = 5'd5;
  localparam logic [4:0] CH_PEAK_W     = 5'd6;
  localparam logic [4:0] CH_AREA_D     = 5'd7;
  localparam logic [4:0] CH_PEAK_D     = 5'd8;
  localparam logic [4:0] CH_AREA_DD    = 5'd9;
  localparam logic [4:0] CH_PEAK_DD    = 5'd10;
  localparam logic [4:0] CH_AREA_XD    = 5'd11;
  localparam logic [4:0] CH_PEAK_XD    = 5'd12;
  localparam logic [4:0] CH_AREA_XDD   = 5'd13;
  localparam logic [4:0] CH_PEAK_XDD   = 5'd14;
  localparam logic [4:0] CH_AREA_SQ    = 5'd15;
  localparam logic [4:0] CH_PEAK_SQ    = 5'd16;
  localparam logic [4:0] CH_DOUBLE     = 5'd17;
  localparam logic [4:0] CH_MAX_PEAK_D = 5'd18;

  typedef enum logic [2:0] {
    K_ZERO, K_DIRECT, K_DIVW, K_DIVD, K_DIVDD, K_MULD, K_MULDD, K_SQRT
  } kind_t;

  typedef enum logic [1:0] {M_HOLD, M_DIV, M_SQRT} mode_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] v;
    logic [15:0] distance;
    logic [15:0] width;
    logic [31:0] direct;
  } s1_lane_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] v;
    logic [15:0] width;
    logic [15:0] distance;
    logic [31:0] vd;
    logic [31:0] dd;
    logic [31:0] direct;
  } s2_lane_t;

  typedef struct packed {
    mode_t       mode;
    logic [43:0] rem;
    logic [63:0] acc;
    logic [79:0] num;
    logic [31:0] den;
  } it_lane_t;

  // one restoring divide bit or one square root digit
  function automatic it_lane_t iter_step(it_lane_t x);
    it_lane_t    y;
    logic [43:0] r;
    logic [43:0] trial;
    y = x;
    r = '0;
    trial = '0;
    unique case (x.mode)
      M_DIV: begin
        r = {x.rem[42:0], x.num[79]};
        y.num = {x.num[78:0], 1'b0};
        if (r >= {12'd0, x.den}) begin
          y.rem = r - {12'd0, x.den};
          y.acc = {x.acc[62:0], 1'b1};
        end else begin
          y.rem = r;
          y.acc = {x.acc[62:0], 1'b0};
        end
      end
      M_SQRT: begin
        r = {x.rem[41:0], x.num[79:78]};
        trial = {x.acc[41:0], 2'b01};
        y.num = {x.num[77:0], 2'b00};
        if (r >= trial) begin
          y.rem = r - trial;
          y.acc = {x.acc[62:0], 1'b1};
        end else begin
          y.rem = r;
          y.acc = {x.acc[62:0], 1'b0};
        end
      end
      default: y = x;
    endcase
    return y;
  endfunction

endpackage

>>> rtl/lidar_echo_feature_pixel.sv
// lidar echo feature pixel: per-pixel feature extraction pipeline
//
//  channel | ports                                         | direction
//  in      | in_valid in_ready in_ambient_level in_echo_*   | pixel in
//  out     | out_valid out_ready out_value_*               | result out
//  cfg     | cfg_we cfg_wdata                              | channel select write
//
// one pixel may enter each cycle unless out_ready stalls; stages: decode,
// two multiply stages, 40 one-digit stages shared by divide and square root
// rst_n (synchronous) clears the valid bits and the channel select
// a stall on out_ready freezes every stage at once, so in_ready follows it
module lidar_echo_feature_pixel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_ambient_level,
  input  logic [55:0] in_echo_first,
  input  logic [55:0] in_echo_second,
  input  logic [55:0] in_echo_third,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_value_first,
  output logic [63:0] out_value_second,
  output logic [63:0] out_value_third,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);

`include "lidar_echo_feature_pixel_defines.svh"

  localparam int unsigned NI = lefp_pkg::NumIter;
  localparam int unsigned NE = lefp_pkg::NumEcho;

  logic [4:0] ch_r;
  logic       adv;

  logic                s1_vld_r;
  lefp_pkg::s1_lane_t  s1_r   [NE];
  lefp_pkg::s1_lane_t  s1_nxt [NE];
  logic                s2_vld_r;
  lefp_pkg::s2_lane_t  s2_r   [NE];
  logic                it_vld_r [NI+1];
  lefp_pkg::it_lane_t  it_r     [NI+1][NE];
  lefp_pkg::it_lane_t  it0_nxt  [NE];

  logic [55:0] ech [NE];
  logic        dbl_ok;
  logic [16:0] twice;
  logic [16:0] diff;
  logic [21:0] diff25;
  logic [7:0]  best;
  logic [15:0] bdist;

  logic        single_ch;
  logic        unused_ch;
  logic        hi_zero;

  // whole pipe advances unless the result is held
  assign adv       = !it_vld_r[NI] || out_ready;
  assign in_ready  = adv;
  assign out_valid = it_vld_r[NI];
  assign out_value_first  = it_r[NI][0].acc;
  assign out_value_second = it_r[NI][1].acc;
  assign out_value_third  = it_r[NI][2].acc;

  // channel select register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= lefp_pkg::CH_AMBIENT;
    end else if (cfg_we) begin
      ch_r <= cfg_wdata;
    end
  end

  assign ech[0] = in_echo_first;
  assign ech[1] = in_echo_second;
  assign ech[2] = in_echo_third;

  // doubled echo test and strongest echo search
  always_comb begin
    twice  = {ech[0][15:0], 1'b0};
    diff   = ({1'b0, ech[1][15:0]} > twice) ? ({1'b0, ech[1][15:0]} - twice)
                                            : (twice - {1'b0, ech[1][15:0]});
    diff25 = diff * lefp_pkg::Tol;
    dbl_ok = (ech[0][15:0] != 16'd0) && (ech[0][15:0] < lefp_pkg::LimDst) &&
             (ech[1][15:0] != 16'd0) && (ech[1][15:0] < lefp_pkg::LimDst) &&
             (diff25 < {6'd0, ech[0][15:0]});
    best  = '0;
    bdist = '0;
    for (int e = 0; e < NE; e++) begin
      if ((ech[e][15:0] != 16'd0) && (ech[e][15:0] < lefp_pkg::LimDst) &&
          (ech[e][39:32] > best)) begin
        best  = ech[e][39:32];
        bdist = ech[e][15:0];
      end
    end
  end

  // stage 1 lane decode
  always_comb begin
    logic [15:0] distance, area, width, v;
    logic [7:0]  peak;
    logic        vok, dok, wok;
    for (int e = 0; e < NE; e++) begin
      distance = ech[e][15:0];
      area     = ech[e][31:16];
      peak     = ech[e][39:32];
      width    = ech[e][55:40];
      v     = ch_r[0] ? area : {8'd0, peak};
      vok   = ch_r[0] ? ((area != 16'd0) && (area < lefp_pkg::Lim16))
                      : ((peak != 8'd0) && (peak < lefp_pkg::Lim8));
      dok   = (distance != 16'd0) && (distance < lefp_pkg::Lim16);
      wok   = (width != 16'd0) && (width < lefp_pkg::Lim16);
      s1_nxt[e].v        = v;
      s1_nxt[e].distance = distance;
      s1_nxt[e].width    = width;
      s1_nxt[e].direct   = '0;
      s1_nxt[e].kind     = lefp_pkg::K_ZERO;
      case (ch_r) inside
        lefp_pkg::CH_AMBIENT: begin
          if (e == 0) begin
            s1_nxt[e].kind = lefp_pkg::K_DIRECT;
            if (in_ambient_level <= lefp_pkg::Lim16)
              s1_nxt[e].direct = {in_ambient_level, 16'd0};
          end
        end
        lefp_pkg::CH_DIST: begin
          s1_nxt[e].kind = lefp_pkg::K_DIRECT;
          if (distance <= lefp_pkg::Lim16) s1_nxt[e].direct = {distance, 16'd0};
        end
        lefp_pkg::CH_AREA: begin
          s1_nxt[e].kind = lefp_pkg::K_DIRECT;
          if (area <= lefp_pkg::Lim16) s1_nxt[e].direct = {area, 16'd0};
        end
        lefp_pkg::CH_PEAK: begin
          s1_nxt[e].kind = lefp_pkg::K_DIRECT;
          if (peak <= lefp_pkg::Lim8) s1_nxt[e].direct = {8'd0, peak, 16'd0};
        end
        lefp_pkg::CH_WIDTH: begin
          s1_nxt[e].kind = lefp_pkg::K_DIRECT;
          if (width <= lefp_pkg::Lim16) s1_nxt[e].direct = {width, 16'd0};
        end
        lefp_pkg::CH_AREA_W, lefp_pkg::CH_PEAK_W: begin
          if (vok && wok) s1_nxt[e].kind = lefp_pkg::K_DIVW;
        end
        lefp_pkg::CH_AREA_D, lefp_pkg::CH_PEAK_D: begin
          if (vok && dok) s1_nxt[e].kind = lefp_pkg::K_DIVD;
        end
        lefp_pkg::CH_AREA_DD, lefp_pkg::CH_PEAK_DD: begin
          if (vok && dok) s1_nxt[e].kind = lefp_pkg::K_DIVDD;
        end
        lefp_pkg::CH_AREA_XD, lefp_pkg::CH_PEAK_XD: begin
          if (vok && dok) s1_nxt[e].kind = lefp_pkg::K_MULD;
        end
        lefp_pkg::CH_AREA_XDD, lefp_pkg::CH_PEAK_XDD: begin
          if (vok && dok) s1_nxt[e].kind = lefp_pkg::K_MULDD;
        end
        lefp_pkg::CH_AREA_SQ, lefp_pkg::CH_PEAK_SQ: begin
          if (vok && dok) s1_nxt[e].kind = lefp_pkg::K_SQRT;
        end
        lefp_pkg::CH_DOUBLE: begin
          s1_nxt[e].kind = lefp_pkg::K_DIRECT;
          if (dbl_ok && (peak < lefp_pkg::PeakHi))
            s1_nxt[e].direct = {8'd0, peak, 16'd0};
        end
        lefp_pkg::CH_MAX_PEAK_D: begin
          if (e == 0) begin
            s1_nxt[e].kind   = lefp_pkg::K_DIRECT;
            s1_nxt[e].direct = {bdist, 16'd0};
          end
        end
        default: s1_nxt[e].kind = lefp_pkg::K_ZERO;
      endcase
    end
  end

  // stage 3 setup of the digit stages, second multiply
  always_comb begin
    logic [47:0] vvd, vdd;
    for (int e = 0; e < NE; e++) begin
      vvd = s2_r[e].vd * s2_r[e].v;
      vdd = s2_r[e].dd * s2_r[e].v;
      it0_nxt[e].mode = lefp_pkg::M_HOLD;
      it0_nxt[e].rem  = '0;
      it0_nxt[e].acc  = '0;
      it0_nxt[e].num  = '0;
      it0_nxt[e].den  = '0;
      unique case (s2_r[e].kind) inside
        lefp_pkg::K_DIRECT: it0_nxt[e].acc = {32'd0, s2_r[e].direct};
        lefp_pkg::K_MULD:   it0_nxt[e].acc = {16'd0, s2_r[e].vd, 16'd0};
        lefp_pkg::K_MULDD:  it0_nxt[e].acc = {vdd, 16'd0};
        lefp_pkg::K_DIVW, lefp_pkg::K_DIVD, lefp_pkg::K_DIVDD: begin
          it0_nxt[e].mode = lefp_pkg::M_DIV;
          it0_nxt[e].num  = {8'd0, s2_r[e].v, 16'd0, 40'd0};
          if (s2_r[e].kind == lefp_pkg::K_DIVW)
            it0_nxt[e].den = {16'd0, s2_r[e].width};
          else if (s2_r[e].kind == lefp_pkg::K_DIVD)
            it0_nxt[e].den = {16'd0, s2_r[e].distance};
          else
            it0_nxt[e].den = s2_r[e].dd;
        end
        lefp_pkg::K_SQRT: begin
          it0_nxt[e].mode = lefp_pkg::M_SQRT;
          it0_nxt[e].num  = {vvd, 32'd0};
        end
        default: it0_nxt[e].mode = lefp_pkg::M_HOLD;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      for (int s = 0; s <= NI; s++) it_vld_r[s] <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= in_valid;
      s2_vld_r    <= s1_vld_r;
      it_vld_r[0] <= s2_vld_r;
      for (int s = 1; s <= NI; s++) it_vld_r[s] <= it_vld_r[s-1];
    end
  end

  // payload stages: decode, first multiply, setup, digit stages
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < NE; e++) begin
        s1_r[e]          <= s1_nxt[e];
        s2_r[e].kind     <= s1_r[e].kind;
        s2_r[e].v        <= s1_r[e].v;
        s2_r[e].width    <= s1_r[e].width;
        s2_r[e].distance <= s1_r[e].distance;
        s2_r[e].vd       <= s1_r[e].v * s1_r[e].distance;
        s2_r[e].dd       <= s1_r[e].distance * s1_r[e].distance;
        s2_r[e].direct   <= s1_r[e].direct;
        it_r[0][e]       <= it0_nxt[e];
        for (int s = 1; s <= NI; s++) it_r[s][e] <= lefp_pkg::iter_step(it_r[s-1][e]);
      end
    end
  end

  // checks
  assign single_ch = (ch_r == lefp_pkg::CH_AMBIENT) || (ch_r == lefp_pkg::CH_MAX_PEAK_D);
  assign unused_ch = ch_r > lefp_pkg::CH_MAX_PEAK_D;
  assign hi_zero   = (out_value_second == 64'd0) && (out_value_third == 64'd0);

  `LEFP_ASSERT_NEXT(a_enter, in_valid && in_ready, s1_vld_r)
  `LEFP_ASSERT_NOW(a_single, out_valid && single_ch, hi_zero)
  `LEFP_ASSERT_NOW(a_unused, out_valid && unused_ch, hi_zero && out_value_first == 64'd0)

endmodule

>>> sim/lidar_echo_feature_pixel_tb.sv
// testbench for the lidar echo feature pixel block: channel predictor and result checks
module lidar_echo_feature_pixel_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
  } feature_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_ambient_level = '0;
  logic [55:0] in_echo_first = '0;
  logic [55:0] in_echo_second = '0;
  logic [55:0] in_echo_third = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_value_first;
  logic [63:0] out_value_second;
  logic [63:0] out_value_third;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;

  logic [4:0]  cur_channel = lefp_pkg::CH_AMBIENT;
  feature_t    pending_features[$];
  int          mismatches = 0;
  int          pixels_sent = 0;
  int          features_seen = 0;
  bit          hold_off = 1'b0;

  lidar_echo_feature_pixel dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_ambient_level, .in_echo_first,
    .in_echo_second, .in_echo_third, .out_valid, .out_ready, .out_value_first,
    .out_value_second, .out_value_third, .cfg_we, .cfg_wdata
  );

  always #5 clk = ~clk;

  // exact floor of sqrt(n * 2^32), digit by digit
  function automatic logic [63:0] root_q16(logic [47:0] n);
    logic [81:0] rem;
    logic [63:0] root;
    logic [81:0] trial;
    logic [79:0] x;
    rem = '0;
    root = '0;
    x = {n, 32'd0};
    for (int k = 39; k >= 0; k--) begin
      rem = {rem[79:0], x[2*k+1 -: 2]};
      trial = {16'd0, root, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        root = {root[62:0], 1'b1};
      end else begin
        root = {root[62:0], 1'b0};
      end
    end
    return root;
  endfunction

  function automatic bit open_range(logic [15:0] x, logic [15:0] lim);
    return x > 0 && x < lim;
  endfunction

  // feature of one echo for the ratio, product, root and raw channels
  function automatic logic [63:0] echo_value(logic [4:0] ch, logic [55:0] e);
    logic [15:0] distance;
    logic [15:0] area;
    logic [7:0]  peak;
    logic [15:0] width;
    logic [15:0] v;
    logic [15:0] vlim;
    logic [63:0] v64;
    logic [63:0] d64;
    distance = e[15:0];
    area = e[31:16];
    peak = e[39:32];
    width = e[55:40];
    case (ch)
      lefp_pkg::CH_DIST:
        return (distance <= lefp_pkg::Lim16) ? {32'd0, distance, 16'd0} : 64'd0;
      lefp_pkg::CH_AREA:
        return (area <= lefp_pkg::Lim16) ? {32'd0, area, 16'd0} : 64'd0;
      lefp_pkg::CH_PEAK:
        return (peak <= lefp_pkg::Lim8) ? {40'd0, peak, 16'd0} : 64'd0;
      lefp_pkg::CH_WIDTH:
        return (width <= lefp_pkg::Lim16) ? {32'd0, width, 16'd0} : 64'd0;
      default: ;
    endcase
    // odd codes use the area, even codes the peak
    v = ch[0] ? area : {8'd0, peak};
    vlim = ch[0] ? lefp_pkg::Lim16 : {8'd0, lefp_pkg::Lim8};
    if (!open_range(v, vlim)) return 64'd0;
    v64 = {48'd0, v};
    d64 = {48'd0, distance};
    if (ch <= lefp_pkg::CH_PEAK_W) begin
      if (!open_range(width, lefp_pkg::Lim16)) return 64'd0;
      return (v64 << 16) / {48'd0, width};
    end
    if (!open_range(distance, lefp_pkg::Lim16)) return 64'd0;
    case (ch) inside
      lefp_pkg::CH_AREA_D, lefp_pkg::CH_PEAK_D:     return (v64 << 16) / d64;
      lefp_pkg::CH_AREA_DD, lefp_pkg::CH_PEAK_DD:   return (v64 << 16) / (d64 * d64);
      lefp_pkg::CH_AREA_XD, lefp_pkg::CH_PEAK_XD:   return (v64 * d64) << 16;
      lefp_pkg::CH_AREA_XDD, lefp_pkg::CH_PEAK_XDD: return (v64 * d64 * d64) << 16;
      default: return root_q16(48'(v64 * v64 * d64));
    endcase
  endfunction

  function automatic feature_t pixel_features(logic [4:0] ch, logic [15:0] amb,
                                              logic [55:0] e0, logic [55:0] e1,
                                              logic [55:0] e2);
    feature_t    f;
    logic [55:0] es[3];
    logic [17:0] twice;
    logic [17:0] diff;
    logic [7:0]  best;
    f = '{64'd0, 64'd0, 64'd0};
    es = '{e0, e1, e2};
    if (ch == lefp_pkg::CH_AMBIENT) begin
      f.v0 = (amb <= lefp_pkg::Lim16) ? {32'd0, amb, 16'd0} : 64'd0;
    end else if (ch <= lefp_pkg::CH_PEAK_SQ) begin
      f.v0 = echo_value(ch, e0);
      f.v1 = echo_value(ch, e1);
      f.v2 = echo_value(ch, e2);
    end else if (ch == lefp_pkg::CH_DOUBLE) begin
      // echo 1 at twice the distance of echo 0 within 4 percent
      if (open_range(e0[15:0], lefp_pkg::LimDst) &&
          open_range(e1[15:0], lefp_pkg::LimDst)) begin
        twice = {1'b0, e0[15:0], 1'b0};
        diff = ({2'd0, e1[15:0]} > twice) ? {2'd0, e1[15:0]} - twice
                                          : twice - {2'd0, e1[15:0]};
        if (diff * 25 < e0[15:0]) begin
          f.v0 = (e0[39:32] < lefp_pkg::PeakHi) ? {40'd0, e0[39:32], 16'd0} : 64'd0;
          f.v1 = (e1[39:32] < lefp_pkg::PeakHi) ? {40'd0, e1[39:32], 16'd0} : 64'd0;
          f.v2 = (e2[39:32] < lefp_pkg::PeakHi) ? {40'd0, e2[39:32], 16'd0} : 64'd0;
        end
      end
    end else if (ch == lefp_pkg::CH_MAX_PEAK_D) begin
      best = '0;
      for (int i = 0; i < 3; i++) begin
        if (open_range(es[i][15:0], lefp_pkg::LimDst) && es[i][39:32] > best) begin
          best = es[i][39:32];
          f.v0 = {32'd0, es[i][15:0], 16'd0};
        end
      end
    end
    return f;
  endfunction

  function automatic logic [55:0] make_echo(logic [15:0] d, logic [15:0] a,
                                            logic [7:0] p, logic [15:0] w);
    return {w, p, a, d};
  endfunction

  // random field value biased toward the edges
  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'(65532 + $urandom_range(0, 3));
      2: return 16'($urandom_range(1, 20));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick8();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'(252 + $urandom_range(0, 3));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [55:0] rand_echo();
    return make_echo(pick16(), pick16(), pick8(), pick16());
  endfunction

  // one pixel transfer, with an optional random gap before it
  task automatic send_pixel(logic [15:0] amb, logic [55:0] e0, logic [55:0] e1,
                            logic [55:0] e2, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 19) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ambient_level <= amb;
    in_echo_first <= e0;
    in_echo_second <= e1;
    in_echo_third <= e2;
    pending_features.push_back(pixel_features(cur_channel, amb, e0, e1, e2));
    pixels_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_features.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_channel(logic [4:0] ch);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= ch;
    cur_channel = ch;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: a random wait before each result, or a long hold-off when asked
  initial begin
    int idle;
    forever begin
      idle = $urandom_range(0, 19);
      if (idle != 0 || hold_off) begin
        out_ready <= 1'b0;
        repeat (idle) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // compare every result transfer with the oldest prediction
  always @(posedge clk) begin
    feature_t want;
    if (rst_n && out_valid && out_ready) begin
      features_seen++;
      if (pending_features.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_value_first);
      end else begin
        want = pending_features.pop_front();
        if (out_value_first !== want.v0 || out_value_second !== want.v1 ||
            out_value_third !== want.v2) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch ch %0d: exp %h %h %h got %h %h %h", cur_channel,
                     want.v0, want.v1, want.v2, out_value_first,
                     out_value_second, out_value_third);
        end
      end
    end
  end

  task automatic test_edges();
    logic [4:0] ch;
    for (int c = 0; c < 21; c++) begin
      ch = (c == 19) ? 5'd31 : (c == 20) ? 5'd19 : 5'(c);
      set_channel(ch);
      send_pixel(16'hFFFF, make_echo(16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF),
                 make_echo(16'd65533, 16'd65533, 8'd253, 16'd65533),
                 make_echo(16'd65532, 16'd65532, 8'd252, 16'd65532), 1'b0);
      send_pixel(16'd0, '0, make_echo(16'd1, 16'd1, 8'd1, 16'd1),
                 make_echo(16'd65534, 16'd65534, 8'd254, 16'd65534), 1'b0);
    end
  endtask

  task automatic test_doubled_echo();
    logic [15:0] d0;
    set_channel(lefp_pkg::CH_DOUBLE);
    for (int i = 0; i < 40; i++) begin
      d0 = 16'($urandom_range(1, 32000));
      send_pixel(16'($urandom), make_echo(d0, pick16(), pick8(), pick16()),
                 make_echo(16'(2 * d0 + $urandom_range(0, d0 / 12 + 2) - d0 / 24),
                           pick16(), pick8(), pick16()), rand_echo(), 1'b1);
    end
  endtask

  task automatic test_max_peak();
    logic [7:0] p;
    set_channel(lefp_pkg::CH_MAX_PEAK_D);
    for (int i = 0; i < 30; i++) begin
      p = pick8();
      send_pixel(16'($urandom), make_echo(pick16(), pick16(), p, pick16()),
                 make_echo(pick16(), pick16(), p, pick16()), rand_echo(), 1'b1);
    end
  endtask

  task automatic test_random_channels();
    for (int ph = 0; ph < 24; ph++) begin
      set_channel(5'($urandom_range(0, 18)));
      for (int i = 0; i < 26; i++)
        send_pixel(pick16(), rand_echo(), rand_echo(), rand_echo(), ph % 4 != 0);
    end
  endtask

  // hold the receiver off so the pipeline fills and stalls the sender
  task automatic test_backpressure();
    set_channel(lefp_pkg::CH_AREA_SQ);
    fork
      begin
        hold_off = 1'b1;
        repeat (150) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 70; i++)
        send_pixel(pick16(), rand_echo(), rand_echo(), rand_echo(), 1'b0);
    join
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edges();
    test_doubled_echo();
    test_max_peak();
    test_backpressure();
    test_random_channels();
    set_channel(lefp_pkg::CH_AMBIENT);
    $display("sent %0d pixels over all channels, checked %0d results",
             pixels_sent, features_seen);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #3ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/lefp_pkg.sv
rtl/lidar_echo_feature_pixel.sv
sim/lidar_echo_feature_pixel_tb.sv
